### hw/rtl/rola_pkg.sv
package rola_pkg;

    // default store and layer sizes
    localparam int ROLA_MAX_SHAPES = 64;
    localparam int ROLA_MAX_LAYERS = 64;

    // width of the layer and column result fields
    localparam int ROLA_OUT_W = 6;

    // one stored rectangle: centre, width and height in units of 1/16
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        w;
        logic [15:0]        h;
    } t_rect;

endpackage

### hw/rtl/rect_overlap_layer_assign.sv
// chan handshake                   words carry
// in   i_in_valid, o_in_ready    i_mode, i_center_x, i_center_y, i_rect_width, i_rect_height
// out  o_out_valid, i_out_ready  o_assigned_layer, o_layer_column, o_store_full
//
// an add passes the states scan, read, write and finish: the running
// maximum walks the chain of cells one cell per cycle, then the read state reads and
// the write state writes the per-layer count memory. a clear or a store-full reject
// goes straight to finish, a reject at the layer limit goes from read to finish.
// reset (i_rst_n low, synchronous) empties the store and the layer counts at once.
// a new word is accepted while the previous result still waits in the output register;
// the next result then holds the block until that register is taken.
module rect_overlap_layer_assign #(
    parameter int MAX_SHAPES = rola_pkg::ROLA_MAX_SHAPES,
    parameter int MAX_LAYERS = rola_pkg::ROLA_MAX_LAYERS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic signed [15:0]            i_center_x,
    input  logic signed [15:0]            i_center_y,
    input  logic [15:0]                   i_rect_width,
    input  logic [15:0]                   i_rect_height,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rola_pkg::ROLA_OUT_W-1:0] o_assigned_layer,
    output logic [rola_pkg::ROLA_OUT_W-1:0] o_layer_column,
    output logic                          o_store_full
);
    import rola_pkg::*;

    localparam int IW = $clog2(MAX_SHAPES);
    localparam int CW = $clog2(MAX_SHAPES + 1);
    localparam int LW = $clog2(MAX_LAYERS);
    localparam int UW = $clog2(MAX_LAYERS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_WRITE,
        ST_FINISH
    } t_state;

    t_state             r_state;
    t_rect              r_q;
    logic [IW-1:0]      r_scan;
    logic [CW-1:0]      r_entry_count;
    logic [UW-1:0]      r_layers_used;
    logic [LW-1:0]      r_layer;
    logic [CW-1:0]      r_cnt_rd;
    logic [LW-1:0]      r_res_layer;
    logic [CW-1:0]      r_res_col;
    logic               r_res_full;
    logic               r_out_valid;
    logic [ROLA_OUT_W-1:0] r_out_layer;
    logic [ROLA_OUT_W-1:0] r_out_col;
    logic               r_out_full;

    logic [CW-1:0]      r_lcnt_mem [MAX_LAYERS];

    logic               w_hit [MAX_SHAPES];
    logic [LW-1:0]      w_top [MAX_SHAPES];

    logic               w_accept;
    logic               w_out_free;
    logic [LW:0]        n_layer;
    logic               n_reject;
    logic [CW-1:0]      n_col;
    logic               n_new_layer;
    logic [LW+ROLA_OUT_W-1:0] w_layer_ext;
    logic [CW+ROLA_OUT_W-1:0] w_col_ext;

    assign o_in_ready = r_state == ST_IDLE;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // chain of cells, the running maximum moves one cell per cycle
    for (genvar k = 0; k < MAX_SHAPES; k++) begin : g_cell
        logic          w_in_hit;
        logic [LW-1:0] w_in_top;
        if (k == 0) begin : g_head
            assign w_in_hit = 1'b0;
            assign w_in_top = '0;
        end else begin : g_link
            assign w_in_hit = w_hit[k-1];
            assign w_in_top = w_top[k-1];
        end
        rola_cell #(
            .IDX (k),
            .CW  (CW),
            .IW  (IW),
            .LW  (LW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_count    (r_entry_count),
            .i_wr_en    (r_state == ST_WRITE),
            .i_wr_idx   (r_entry_count[IW-1:0]),
            .i_wr_layer (r_layer),
            .i_query    (r_q),
            .i_hit      (w_in_hit),
            .i_top      (w_in_top),
            .o_hit      (w_hit[k]),
            .o_top      (w_top[k])
        );
    end

    always_comb begin
        n_layer     = w_hit[MAX_SHAPES-1] ? ((LW+1)'(w_top[MAX_SHAPES-1]) + 1'b1) : '0;
        n_reject    = n_layer >= (LW+1)'(MAX_LAYERS);
        // layers at or above the used count hold no entries yet
        n_new_layer = UW'(r_layer) >= r_layers_used;
        n_col       = n_new_layer ? '0 : r_cnt_rd;
        w_layer_ext = (LW+ROLA_OUT_W)'(r_res_layer);
        w_col_ext   = (CW+ROLA_OUT_W)'(r_res_col);
    end

    always_ff @(posedge i_clk) begin
        r_cnt_rd <= r_lcnt_mem[n_layer[LW-1:0]];
        if (r_state == ST_WRITE) begin
            r_lcnt_mem[r_layer] <= n_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_entry_count <= '0;
            r_layers_used <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_q         <= '{x: i_center_x, y: i_center_y,
                                         w: i_rect_width, h: i_rect_height};
                        r_scan      <= '0;
                        r_res_layer <= '0;
                        r_res_col   <= '0;
                        r_res_full  <= 1'b0;
                        if (i_mode) begin
                            r_entry_count <= '0;
                            r_layers_used <= '0;
                            r_state       <= ST_FINISH;
                        end else if (r_entry_count == CW'(MAX_SHAPES)) begin
                            r_res_full <= 1'b1;
                            r_state    <= ST_FINISH;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_scan == IW'(MAX_SHAPES - 1)) begin
                        r_state <= ST_READ;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                ST_READ: begin
                    r_layer <= n_layer[LW-1:0];
                    if (n_reject) begin
                        r_res_full <= 1'b1;
                        r_state    <= ST_FINISH;
                    end else begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_entry_count <= r_entry_count + 1'b1;
                    if (n_new_layer) begin
                        r_layers_used <= UW'(r_layer) + 1'b1;
                    end
                    r_res_layer <= r_layer;
                    r_res_col   <= n_col;
                    r_state     <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_layer <= w_layer_ext[ROLA_OUT_W-1:0];
                        r_out_col   <= w_col_ext[ROLA_OUT_W-1:0];
                        r_out_full  <= r_res_full;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_assigned_layer = r_out_layer;
    assign o_layer_column   = r_out_col;
    assign o_store_full     = r_out_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_count <= CW'(MAX_SHAPES))
        else $error("entry count above store size");

    a_layers_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_layers_used <= UW'(MAX_LAYERS))
        else $error("layers used above layer limit");

    a_no_layer_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WRITE |-> UW'(r_layer) <= r_layers_used)
        else $error("new layer skips an empty layer");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_mode |=> r_entry_count == '0 && r_layers_used == '0)
        else $error("clear left entries behind");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_store_full |-> o_assigned_layer == '0 && o_layer_column == '0)
        else $error("rejected word carries a layer or column");

endmodule

### hw/rtl/rola_cell.sv
module rola_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7,
    parameter int IW  = 6,
    parameter int LW  = 6
) (
    input  logic           i_clk,
    input  logic [CW-1:0]  i_count,
    input  logic           i_wr_en,
    input  logic [IW-1:0]  i_wr_idx,
    input  logic [LW-1:0]  i_wr_layer,
    input  rola_pkg::t_rect i_query,
    input  logic           i_hit,
    input  logic [LW-1:0]  i_top,
    output logic           o_hit,
    output logic [LW-1:0]  o_top
);
    import rola_pkg::*;

    t_rect          r_rect;
    logic [LW-1:0]  r_layer;
    logic           r_hit;
    logic [LW-1:0]  r_top;

    logic               w_valid;
    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;
    logic [16:0]        w_adx;
    logic [16:0]        w_ady;
    logic [16:0]        w_wsum;
    logic [16:0]        w_hsum;
    logic               w_touch;
    logic               n_hit;
    logic [LW-1:0]      n_top;

    // entries below the fill count are live
    assign w_valid = i_count > CW'(IDX);

    always_comb begin
        w_dx   = 17'(r_rect.x) - 17'(i_query.x);
        w_dy   = 17'(r_rect.y) - 17'(i_query.y);
        w_adx  = w_dx[16] ? 17'(-w_dx) : 17'(w_dx);
        w_ady  = w_dy[16] ? 17'(-w_dy) : 17'(w_dy);
        w_wsum = 17'(r_rect.w) + 17'(i_query.w);
        w_hsum = 17'(r_rect.h) + 17'(i_query.h);
        // inclusive overlap, touching edges count
        w_touch = w_valid &&
                  ({1'b0, w_adx} << 1) <= {1'b0, w_wsum} &&
                  ({1'b0, w_ady} << 1) <= {1'b0, w_hsum};
        n_hit = i_hit | w_touch;
        if (w_touch && (!i_hit || r_layer > i_top)) begin
            n_top = r_layer;
        end else begin
            n_top = i_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_idx == IW'(IDX)) begin
            r_rect  <= i_query;
            r_layer <= i_wr_layer;
        end
        r_hit <= n_hit;
        r_top <= n_top;
    end

    assign o_hit = r_hit;
    assign o_top = r_top;

endmodule

### dv/rect_overlap_layer_assign_tb.sv
`timescale 1ns / 100ps

module rect_overlap_layer_assign_tb;
    import rola_pkg::*;

    localparam int  SHAPE_SLOTS  = ROLA_MAX_SHAPES;
    localparam int  LAYER_SLOTS  = ROLA_MAX_LAYERS;
    localparam bit  MODE_ADD     = 1'b0;
    localparam bit  MODE_CLEAR   = 1'b1;
    localparam int  LIMIT_CYCLES = 600000;
    localparam int  WORD_GOAL    = 1120;
    localparam int  MAX_REPORTS  = 10;

    typedef struct {
        bit    mode;
        t_rect r;
        bit    drain_first;
    } t_rect_word;

    typedef struct packed {
        logic [ROLA_OUT_W-1:0] layer;
        logic [ROLA_OUT_W-1:0] column;
        logic                  full;
    } t_place_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_mode = 1'b0;
    logic signed [15:0]    i_center_x = '0;
    logic signed [15:0]    i_center_y = '0;
    logic [15:0]           i_rect_width = '0;
    logic [15:0]           i_rect_height = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [ROLA_OUT_W-1:0] o_assigned_layer;
    logic [ROLA_OUT_W-1:0] o_layer_column;
    logic                  o_store_full;

    rect_overlap_layer_assign uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_center_x       (i_center_x),
        .i_center_y       (i_center_y),
        .i_rect_width     (i_rect_width),
        .i_rect_height    (i_rect_height),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_assigned_layer (o_assigned_layer),
        .o_layer_column   (o_layer_column),
        .o_store_full     (o_store_full)
    );

    // predictor state
    t_rect      shape_store [SHAPE_SLOTS];
    int         shape_layer [SHAPE_SLOTS];
    int         shape_total = 0;
    int         layer_total [LAYER_SLOTS];

    t_rect_word    pending_words [$];
    t_place_result result_expected [$];
    t_rect_word    offered_word;

    int  words_taken = 0;
    int  results_checked = 0;
    int  mismatches = 0;
    int  full_seen = 0;
    int  top_layer_seen = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  take_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  idle_on = 1'b0;

    // inclusive test: touching edges count
    function automatic bit rects_meet(t_rect a, t_rect b);
        int dx;
        int dy;
        int ax;
        int bx;
        int ay;
        int by;
        ax = $signed(a.x);
        bx = $signed(b.x);
        ay = $signed(a.y);
        by = $signed(b.y);
        dx = ax - bx;
        dy = ay - by;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return (2 * dx <= int'(a.w) + int'(b.w)) && (2 * dy <= int'(a.h) + int'(b.h));
    endfunction

    function automatic t_place_result place_rect(t_rect_word wd);
        t_place_result res;
        bit            hit;
        int            top;
        int            lyr;
        res = '0;
        if (wd.mode == MODE_CLEAR) begin
            shape_total = 0;
            for (int k = 0; k < LAYER_SLOTS; k++) layer_total[k] = 0;
            return res;
        end
        if (shape_total >= SHAPE_SLOTS) begin
            res.full = 1'b1;
            return res;
        end
        hit = 1'b0;
        top = 0;
        for (int i = 0; i < shape_total; i++) begin
            if (rects_meet(shape_store[i], wd.r)) begin
                if (!hit || shape_layer[i] > top) top = shape_layer[i];
                hit = 1'b1;
            end
        end
        lyr = hit ? top + 1 : 0;
        if (lyr >= LAYER_SLOTS) begin
            res.full = 1'b1;
            return res;
        end
        shape_store[shape_total] = wd.r;
        shape_layer[shape_total] = lyr;
        shape_total++;
        res.layer  = lyr[ROLA_OUT_W-1:0];
        res.column = layer_total[lyr][ROLA_OUT_W-1:0];
        layer_total[lyr]++;
        return res;
    endfunction

    task automatic queue_word(bit m, int x, int y, int w, int h, bit drain);
        t_rect_word wd;
        wd.mode        = m;
        wd.r.x         = x[15:0];
        wd.r.y         = y[15:0];
        wd.r.w         = w[15:0];
        wd.r.h         = h[15:0];
        wd.drain_first = drain;
        pending_words.push_back(wd);
    endtask

    task automatic queue_clear(bit drain);
        queue_word(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, drain);
    endtask

    task automatic queue_directed();
        queue_word(MODE_CLEAR, -1, -1, 65535, 65535, 1'b0);
        queue_word(MODE_ADD, -32768, 32767, 0, 0, 1'b0);
        queue_word(MODE_ADD, 32767, -32768, 65535, 65535, 1'b0);
        queue_word(MODE_ADD, 32767, -32768, 0, 0, 1'b0);
        // zero size on the very same point still overlaps
        queue_word(MODE_ADD, -32768, 32767, 0, 0, 1'b0);
        queue_word(MODE_CLEAR, 0, 0, 0, 0, 1'b0);
        queue_word(MODE_ADD, 0, 0, 32, 32, 1'b0);
        queue_word(MODE_ADD, 32, 0, 32, 32, 1'b0);
        queue_word(MODE_ADD, 0, 33, 32, 32, 1'b0);
        queue_word(MODE_ADD, -32, -32, 32, 32, 1'b0);
        queue_word(MODE_ADD, 16, 16, 0, 0, 1'b0);
        for (int i = 0; i < 5; i++) queue_word(MODE_ADD, 100, 100, 50, 50, 1'b0);
        queue_word(MODE_ADD, 0, 0, 65535, 65535, 1'b0);
        queue_word(MODE_CLEAR, 21845, -21846, 43690, 21845, 1'b0);
        queue_word(MODE_ADD, 1, -1, 1, 1, 1'b0);
        queue_word(MODE_ADD, -32768, -32768, 65535, 65535, 1'b0);
        queue_word(MODE_CLEAR, 0, 0, 0, 0, 1'b0);
    endtask

    task automatic queue_random();
        int episode;
        int kind;
        int n;
        int bx;
        int by;
        int sz;
        episode = 0;
        while (pending_words.size() < WORD_GOAL) begin
            queue_clear(episode % 12 == 0);
            kind = $urandom_range(0, 9);
            bx = int'($urandom_range(0, 60000)) - 30000;
            by = int'($urandom_range(0, 60000)) - 30000;
            case (kind)
                0, 1, 2, 3: begin
                    n = $urandom_range(4, 40);
                    for (int i = 0; i < n; i++) begin
                        if ($urandom_range(0, 39) == 0) queue_clear(1'b0);
                        else queue_word(MODE_ADD,
                                        bx + int'($urandom_range(0, 400)) - 200,
                                        by + int'($urandom_range(0, 400)) - 200,
                                        $urandom_range(0, 300), $urandom_range(0, 300), 1'b0);
                    end
                end
                4, 5: begin
                    // all mutually overlapping: may climb to the top layer and fill
                    n = $urandom_range(60, 70);
                    for (int i = 0; i < n; i++) begin
                        sz = $urandom_range(100, 4000);
                        queue_word(MODE_ADD, bx + int'($urandom_range(0, 100)) - 50,
                                   by + int'($urandom_range(0, 100)) - 50,
                                   sz, sz + int'($urandom_range(0, 60)), 1'b0);
                    end
                end
                6: begin
                    n = $urandom_range(10, 30);
                    for (int i = 0; i < n; i++)
                        queue_word(MODE_ADD, $urandom, $urandom, $urandom, $urandom, 1'b0);
                end
                7: begin
                    // edge-sharing grid cells
                    n = $urandom_range(10, 40);
                    for (int i = 0; i < n; i++)
                        queue_word(MODE_ADD, bx + 32 * int'($urandom_range(0, 7)),
                                   by + 32 * int'($urandom_range(0, 7)), 32, 32, 1'b0);
                end
                default: begin
                    n = $urandom_range(64, 72);
                    for (int i = 0; i < n; i++)
                        queue_word(MODE_ADD,
                                   bx + int'($urandom_range(0, 2000)) - 1000,
                                   by + int'($urandom_range(0, 2000)) - 1000,
                                   $urandom_range(0, 900), $urandom_range(0, 900), 1'b0);
                end
            endcase
            episode++;
        end
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // sender
    always @(posedge i_clk) begin : drive_proc
        t_rect_word nx;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                result_expected.push_back(place_rect(offered_word));
                words_taken <= words_taken + 1;
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the word until taken
            end else if (send_gap > 0) begin
                send_gap = send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() == 0 ||
                         (pending_words[0].drain_first &&
                          (result_expected.size() != 0 || (i_in_valid && o_in_ready)))) begin
                i_in_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(1, 12) - 1;
                i_in_valid <= 1'b0;
            end else begin
                nx = pending_words.pop_front();
                offered_word = nx;
                i_mode        <= nx.mode;
                i_center_x    <= nx.r.x;
                i_center_y    <= nx.r.y;
                i_rect_width  <= nx.r.w;
                i_rect_height <= nx.r.h;
                i_in_valid    <= 1'b1;
            end
        end
    end

    // one long receiver stall so the input side backs up
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && words_taken >= 300) begin
            hold_left <= 700;
            hold_done <= 1'b1;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : check_proc
        t_place_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (result_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected word: layer %0d column %0d full %0d",
                                 o_assigned_layer, o_layer_column, o_store_full);
                end else begin
                    want = result_expected.pop_front();
                    results_checked++;
                    if (o_store_full) full_seen++;
                    if (int'(o_assigned_layer) > top_layer_seen)
                        top_layer_seen = o_assigned_layer;
                    if (o_assigned_layer !== want.layer || o_layer_column !== want.column ||
                        o_store_full !== want.full) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch %0d: exp L%0d C%0d F%0d got L%0d C%0d F%0d",
                                     results_checked, want.layer, want.column, want.full,
                                     o_assigned_layer, o_layer_column, o_store_full);
                    end
                end
            end
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap = take_gap - 1;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                take_gap = $urandom_range(1, 12) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // cycle limit; idling runs in stretches and stops near the end
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        idle_on <= ((words_taken / 96) % 3 != 2) && (pending_words.size() > 120);
        if (cycle_count == LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < LAYER_SLOTS; k++) layer_total[k] = 0;
        queue_directed();
        queue_random();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_words.size() != 0 || i_in_valid || result_expected.size() != 0)
            @(posedge i_clk);
        repeat (SHAPE_SLOTS + 40) @(posedge i_clk);
        $display("sent %0d words, checked %0d results, %0d store-full rejects",
                 words_taken, results_checked, full_seen);
        $display("highest layer reached %0d, mismatches %0d", top_layer_seen, mismatches);
        if (mismatches == 0 && result_expected.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
